>>> rtl/fir_filter_100_tap_unit_defines.svh
// Assertion macros for the FIR unit
`ifndef FIR_FILTER_100_TAP_UNIT_DEFINES_SVH
`define FIR_FILTER_100_TAP_UNIT_DEFINES_SVH
`ifndef SYNTH
`define FIR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FIR_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FIR_ASSERT(lbl, clk, rst_n, prop, msg)
`define FIR_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/fir100_pkg.sv
package fir100_pkg;
    localparam int unsigned TapsDefault   = 100;
    localparam int unsigned SampleBitsDef = 16;
    localparam int unsigned RomSize       = 100;
    localparam int unsigned CoefBits      = 12;
    localparam int unsigned OutBits       = 32;

    function automatic logic [CoefBits-1:0] coef_at(input logic [8:0] k);
        logic [CoefBits-1:0] c;
        begin
            case (k)
                9'd0: c = 12'd31;    9'd1: c = 12'd1152;  9'd2: c = 12'd845;
                9'd3: c = 12'd384;   9'd4: c = 12'd230;   9'd5: c = 12'd717;
                9'd6: c = 12'd1050;  9'd7: c = 12'd947;   9'd8: c = 12'd563;
                9'd9: c = 12'd358;   9'd10: c = 12'd154;  9'd11: c = 12'd1280;
                9'd12: c = 12'd1101; 9'd13: c = 12'd205;  9'd14: c = 12'd742;
                9'd15: c = 12'd896;  9'd16: c = 12'd307;  9'd17: c = 12'd102;
                9'd18: c = 12'd691;  9'd19: c = 12'd410;  9'd20: c = 12'd1229;
                9'd21: c = 12'd640;  9'd22: c = 12'd998;  9'd23: c = 12'd179;
                9'd24: c = 12'd0;    9'd25: c = 12'd589;  9'd26: c = 12'd461;
                9'd27: c = 12'd51;   9'd28: c = 12'd870;  9'd29: c = 12'd1203;
                9'd30: c = 12'd486;  9'd31: c = 12'd666;  9'd32: c = 12'd77;
                9'd33: c = 12'd973;  9'd34: c = 12'd282;  9'd35: c = 12'd1024;
                9'd36: c = 12'd538;  9'd37: c = 12'd819;  9'd38: c = 12'd333;
                9'd39: c = 12'd128;  9'd40: c = 12'd1126; 9'd41: c = 12'd614;
                9'd42: c = 12'd0;    9'd43: c = 12'd230;  9'd44: c = 12'd1178;
                9'd45: c = 12'd435;  9'd46: c = 12'd205;  9'd47: c = 12'd922;
                9'd48: c = 12'd512;  9'd49: c = 12'd1254; 9'd50: c = 12'd358;
                9'd51: c = 12'd179;  9'd52: c = 12'd742;  9'd53: c = 12'd333;
                9'd54: c = 12'd1075; 9'd55: c = 12'd845;  9'd56: c = 12'd666;
                9'd57: c = 12'd154;  9'd58: c = 12'd973;  9'd59: c = 12'd256;
                9'd60: c = 12'd1203; 9'd61: c = 12'd640;  9'd62: c = 12'd102;
                9'd63: c = 12'd998;  9'd64: c = 12'd307;  9'd65: c = 12'd1024;
                9'd66: c = 12'd691;  9'd67: c = 12'd461;  9'd68: c = 12'd77;
                9'd69: c = 12'd1126; 9'd70: c = 12'd563;  9'd71: c = 12'd870;
                9'd72: c = 12'd384;  9'd73: c = 12'd1229; 9'd74: c = 12'd26;
                9'd75: c = 12'd794;  9'd76: c = 12'd512;  9'd77: c = 12'd1254;
                9'd78: c = 12'd410;  9'd79: c = 12'd947;  9'd80: c = 12'd51;
                9'd81: c = 12'd1178; 9'd82: c = 12'd589;  9'd83: c = 12'd896;
                9'd84: c = 12'd435;  9'd85: c = 12'd1101; 9'd86: c = 12'd128;
                9'd87: c = 12'd768;  9'd88: c = 12'd538;  9'd89: c = 12'd1050;
                9'd90: c = 12'd358;  9'd91: c = 12'd230;  9'd92: c = 12'd717;
                9'd93: c = 12'd922;  9'd94: c = 12'd1152; 9'd95: c = 12'd333;
                9'd96: c = 12'd998;  9'd97: c = 12'd614;  9'd98: c = 12'd205;
                9'd99: c = 12'd1203;
                default: c = '0;
            endcase
            return c;
        end
    endfunction
endpackage

>>> rtl/fir100_if.sv
interface fir100_in_if
    import fir100_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SampleBitsDef
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;
    modport source (output valid, sample, first, input ready);
    modport sink   (input valid, sample, first, output ready);
endinterface

interface fir100_out_if
    import fir100_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [OutBits-1:0] filtered;
    modport source (output valid, filtered, input ready);
    modport sink   (input valid, filtered, output ready);
endinterface

>>> rtl/fir_filter_100_tap_unit.sv
// FIR filter, direct form, fixed coefficient table.
// Input channel: one word = signed sample plus a first flag; first=1 zeroes the
// history before that sample is used (stream start).
// Output channel: one word = signed 32-bit sum of products, an integer not
// shifted by any scale, saturated to 32 bits.
// Operation: a single multiply-accumulate walks the taps, one tap per cycle,
// the coefficient taken from the table and the delay-line tap from a rotating
// shift register (the line rotates one place per cycle, so only its head is
// ever read). The accepting edge loads a word, the mac state walks the TAPS
// taps, and the last mac step hands over to the output state, which
// saturates the sum and shows it on o_out once the result register frees.
// The one shared mac sets the throughput: no new word is taken until the
// output state has passed the last sum on to the result register.
// The result register parts the two sides: a new word is taken while the last
// result still waits, and a stalled receiver holds o_out steady. A finished
// sum waits in the output state until the result register frees.
// Reset (synchronous, active low) zeroes the history and empties the
// pipeline; the history is held in flip-flops and clears all at once.
`include "fir_filter_100_tap_unit_defines.svh"
module fir_filter_100_tap_unit
    import fir100_pkg::*;
#(
    parameter int unsigned TAPS        = TapsDefault,
    parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fir100_in_if.sink    i_in,
    fir100_out_if.source o_out
);
    localparam int unsigned HL   = TAPS - 1;
    localparam int unsigned CW   = $clog2(TAPS + 1);
    localparam int unsigned PW   = SAMPLE_BITS + CoefBits + 1;
    localparam int unsigned AW   = PW + CW + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MAC  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_hist [HL];   // newest first at rest
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [CW-1:0]                 r_cnt;
    logic signed [AW-1:0]          r_acc;
    logic signed [OutBits-1:0]     r_res;
    logic                          r_vld;

    logic                          w_take;
    logic                          w_out_free;
    logic signed [SAMPLE_BITS-1:0] w_tap;
    logic signed [PW-1:0]          w_prod;
    logic [8:0]                    w_k;

    assign i_in.ready     = (r_state == S_IDLE);
    assign w_take         = i_in.valid && i_in.ready;
    // result register empty now or emptied at this edge
    assign w_out_free     = !r_vld || o_out.ready;
    assign o_out.valid    = r_vld;
    assign o_out.filtered = r_res;

    // tap 0 is the new sample, later taps the head of the rotating line
    assign w_tap  = (r_cnt == '0) ? r_x : r_hist[0];
    assign w_k    = 9'(r_cnt);
    assign w_prod = PW'($signed({1'b0, coef_at(w_k)}) * w_tap);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_take) n_state = S_MAC;
            S_MAC:   if (r_cnt == CW'(HL)) n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
            r_cnt   <= '0;
            for (int i = 0; i < HL; i++) r_hist[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free)
                r_vld <= 1'b1;
            else if (o_out.valid && o_out.ready)
                r_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_x   <= i_in.sample;
                        r_cnt <= '0;
                        r_acc <= '0;
                        if (i_in.first)
                            for (int i = 0; i < HL; i++) r_hist[i] <= '0;
                    end
                end
                S_MAC: begin
                    r_acc <= r_acc + AW'(w_prod);
                    r_cnt <= r_cnt + 1'b1;
                    // rotate once per history tap; after HL steps back at rest
                    if (r_cnt != '0) begin
                        for (int i = 0; i < HL - 1; i++) r_hist[i] <= r_hist[i+1];
                        r_hist[HL-1] <= r_hist[0];
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        // shift the new sample in, oldest drops out
                        r_hist[0] <= r_x;
                        for (int i = 1; i < HL; i++) r_hist[i] <= r_hist[i-1];
                        if (r_acc > AW'(32'sh7FFFFFFF))
                            r_res <= 32'sh7FFFFFFF;
                        else if (r_acc < -AW'(33'sh080000000))
                            r_res <= 32'sh80000000;
                        else
                            r_res <= OutBits'(r_acc);
                    end
                end
                default: ;
            endcase
        end
    end

    `FIR_ASSERT(a_onehot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
    `FIR_ASSERT(a_busy, i_clk, i_rst_n, (r_state != S_IDLE) |-> !i_in.ready, "ready while busy")
    `FIR_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out.valid && !o_out.ready) |=> $stable(r_res), "result moved")
    `FIR_ASSERT(a_vld_from_out, i_clk, i_rst_n, $rose(r_vld) |-> $past(r_state) == S_OUT, "stray valid")
endmodule
